>>> hdl/ssq_pkg.sv
// Shared constants, widths and the brush part scale table for the stroke segment quad block.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package ssq_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF   = 4;

  // Width of a direction magnitude after range reduction.
  localparam int unsigned NORM_W    = 15;
  // Squared length of a reduced direction vector.
  localparam int unsigned L2_W      = 2 * NORM_W + 1;
  // The length is computed in Q14, so the radicand is the squared length times 2^28.
  localparam int unsigned LEN_SHIFT = 28;
  localparam int unsigned ROOT_W    = 30;
  localparam int unsigned RAD_W     = 2 * ROOT_W;
  localparam int unsigned REM_W     = ROOT_W + 3;
  // Normalization divide: numerator and quotient widths.
  localparam int unsigned NUM_W     = NORM_W + LEN_SHIFT + 1;
  localparam int unsigned QUO_W     = 16;
  // Brush scaling.
  localparam int unsigned SCALE_W   = 9;
  localparam int unsigned BRUSH_W   = 8;
  localparam int unsigned PROD1_W   = QUO_W + SCALE_W;
  localparam int unsigned PROD2_W   = PROD1_W + BRUSH_W;
  localparam int unsigned ROUND_POS = 23;

  localparam logic [BRUSH_W-1:0] BRUSH_RESET = 8'd16;

  typedef enum logic [1:0] {
    PART_TIP    = 2'd0,
    PART_MID    = 2'd1,
    PART_BASE   = 2'd2,
    PART_UNUSED = 2'd3
  } part_e;

  // Brush part scale in Q1.8. The unused code behaves like the base.
  function automatic logic [SCALE_W-1:0] part_scale(input logic [1:0] sel);
    logic [SCALE_W-1:0] s;
    case (part_e'(sel))
      PART_TIP: s = 9'd84;
      PART_MID: s = 9'd172;
      default:  s = 9'd256;
    endcase
    return s;
  endfunction

endpackage

>>> hdl/ssq_sqrt.sv
// Pipelined integer square root, one result bit per stage, with a sideband carried alongside.
// Depends on ssq_pkg for the radicand and root widths.
module ssq_sqrt #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [ssq_pkg::L2_W-1:0]      l2_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          valid_o,
  output logic [ssq_pkg::ROOT_W-1:0]    root_o,
  output logic [SIDE_W-1:0]             side_o
);

  localparam int unsigned ROOT_W = ssq_pkg::ROOT_W;
  localparam int unsigned RAD_W  = ssq_pkg::RAD_W;
  localparam int unsigned REM_W  = ssq_pkg::REM_W;

  logic [ROOT_W-1:0] v_q;
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [RAD_W-1:0]  rad_q  [ROOT_W];
  logic [SIDE_W-1:0] side_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              v_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    logic [SIDE_W-1:0] side_in;
    logic [REM_W-1:0]  rem_t;
    logic [REM_W-1:0]  trial;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = RAD_W'(l2_i) << ssq_pkg::LEN_SHIFT;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    assign rem_t = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_t >= trial) begin
          rem_q[k]  <= rem_t - trial;
          root_q[k] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_t;
          root_q[k] <= {root_in[ROOT_W-2:0], 1'b0};
        end
        rad_q[k]  <= rad_in << 2;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule

>>> hdl/ssq_div.sv
// Pipelined two-lane restoring divider that turns both direction magnitudes into unit normal
// components (Q2.14, rounded). Depends on ssq_pkg for widths.
module ssq_div #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [ssq_pkg::ROOT_W-1:0]    len_i,
  input  logic [ssq_pkg::NORM_W-1:0]    mag_i [2],
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          valid_o,
  output logic [ssq_pkg::QUO_W-1:0]     quo_o [2],
  output logic [SIDE_W-1:0]             side_o
);

  localparam int unsigned ROOT_W = ssq_pkg::ROOT_W;
  localparam int unsigned NUM_W  = ssq_pkg::NUM_W;
  localparam int unsigned QUO_W  = ssq_pkg::QUO_W;

  // Numerator stage.
  logic              v0_q;
  logic [ROOT_W-1:0] len0_q;
  logic [NUM_W-1:0]  num0_q [2];
  logic [SIDE_W-1:0] side0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len0_q  <= len_i;
      side0_q <= side_i;
      for (int l = 0; l < 2; l++) begin
        num0_q[l] <= (NUM_W'(mag_i[l]) << ssq_pkg::LEN_SHIFT) + NUM_W'(len_i >> 1);
      end
    end
  end

  // One quotient bit per stage. The quotient is known to fit QUO_W bits, so the partial
  // remainder starts from the numerator bits above the quotient field.
  logic [QUO_W-1:0]  v_q;
  logic [ROOT_W-1:0] len_q  [QUO_W];
  logic [ROOT_W-1:0] rem_q  [QUO_W][2];
  logic [QUO_W-1:0]  low_q  [QUO_W][2];
  logic [QUO_W-1:0]  quo_q  [QUO_W][2];
  logic [SIDE_W-1:0] side_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic              v_in;
    logic [ROOT_W-1:0] len_in;
    logic [ROOT_W-1:0] rem_in  [2];
    logic [QUO_W-1:0]  low_in  [2];
    logic [QUO_W-1:0]  quo_in  [2];
    logic [SIDE_W-1:0] side_in;

    if (k == 0) begin : g_first
      assign v_in    = v0_q;
      assign len_in  = len0_q;
      assign side_in = side0_q;
      for (genvar l = 0; l < 2; l++) begin : g_lane
        assign rem_in[l] = ROOT_W'(num0_q[l][NUM_W-1:QUO_W]);
        assign low_in[l] = num0_q[l][QUO_W-1:0];
        assign quo_in[l] = '0;
      end
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign len_in  = len_q[k-1];
      assign side_in = side_q[k-1];
      for (genvar l = 0; l < 2; l++) begin : g_lane
        assign rem_in[l] = rem_q[k-1][l];
        assign low_in[l] = low_q[k-1][l];
        assign quo_in[l] = quo_q[k-1][l];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      logic [ROOT_W:0] rem_t;
      if (en_i) begin
        len_q[k]  <= len_in;
        side_q[k] <= side_in;
        for (int l = 0; l < 2; l++) begin
          rem_t = {rem_in[l], low_in[l][QUO_W-1]};
          if (rem_t >= {1'b0, len_in}) begin
            rem_q[k][l] <= ROOT_W'(rem_t - {1'b0, len_in});
            quo_q[k][l] <= {quo_in[l][QUO_W-2:0], 1'b1};
          end else begin
            rem_q[k][l] <= ROOT_W'(rem_t);
            quo_q[k][l] <= {quo_in[l][QUO_W-2:0], 1'b0};
          end
          low_q[k][l] <= low_in[l] << 1;
        end
      end
    end
  end

  assign valid_o = v_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];
  assign side_o  = side_q[QUO_W-1];

endmodule

>>> hdl/ssq_offset.sv
// Three-stage brush scaling: normal times part scale, times brush size, then rounding and sign.
// Depends on ssq_pkg for widths.
module ssq_offset #(
  parameter int unsigned FRAC_BITS = ssq_pkg::FRAC_BITS_DEF,
  parameter int unsigned SIDE_W    = 1,
  parameter int unsigned OFS_W     = 12 + FRAC_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [ssq_pkg::QUO_W-1:0]         norm_i [2],
  input  logic [1:0]                        neg_i,
  input  logic [ssq_pkg::SCALE_W-1:0]       scale_i,
  input  logic [ssq_pkg::BRUSH_W-1:0]       brush_i,
  input  logic [SIDE_W-1:0]                 side_i,
  output logic                              valid_o,
  output logic signed [OFS_W-1:0]           ofs_o [2],
  output logic [SIDE_W-1:0]                 side_o
);

  localparam int unsigned PROD1_W = ssq_pkg::PROD1_W;
  localparam int unsigned PROD2_W = ssq_pkg::PROD2_W;
  localparam int unsigned SUM_W   = PROD2_W + FRAC_BITS + 1;
  localparam int unsigned MAG_W   = SUM_W - ssq_pkg::ROUND_POS;

  logic [2:0]          v_q;
  logic [PROD1_W-1:0]  p1_q [2];
  logic [PROD2_W-1:0]  p2_q [2];
  logic [1:0]          neg1_q, neg2_q;
  logic [SIDE_W-1:0]   side1_q, side2_q, side3_q;
  logic signed [OFS_W-1:0] ofs_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    logic [SUM_W-1:0] sum;
    logic [MAG_W-1:0] mag;
    if (en_i) begin
      neg1_q  <= neg_i;
      neg2_q  <= neg1_q;
      side1_q <= side_i;
      side2_q <= side1_q;
      side3_q <= side2_q;
      for (int l = 0; l < 2; l++) begin
        p1_q[l] <= PROD1_W'(norm_i[l]) * PROD1_W'(scale_i);
        p2_q[l] <= PROD2_W'(p1_q[l]) * PROD2_W'(brush_i);
        // Round half up on the magnitude, then apply the sign.
        sum = (SUM_W'(p2_q[l]) << FRAC_BITS) + (SUM_W'(1) << (ssq_pkg::ROUND_POS - 1));
        mag = sum[SUM_W-1:ssq_pkg::ROUND_POS];
        if (neg2_q[l]) begin
          ofs_q[l] <= -$signed(OFS_W'(mag));
        end else begin
          ofs_q[l] <= $signed(OFS_W'(mag));
        end
      end
    end
  end

  assign valid_o = v_q[2];
  assign ofs_o   = ofs_q;
  assign side_o  = side3_q;

endmodule

>>> hdl/stroke_segment_quad.sv
// Top level of the stroke segment quad expander: front-end stages, corner stage, output buffer.
// Depends on ssq_pkg, ssq_sqrt, ssq_div and ssq_offset.
//
// Channel   Direction  Handshake                   Payload
// s_axis    in         s_axis_tvalid/tready        tdata: start_x,start_y,end_x,end_y; tuser: part
// m_axis    out        m_axis_tvalid/tready        tdata: corner1_x..corner4_y; tuser: degenerate
// cfg       in         cfg_we_i (no wait)          cfg_wdata_i: brush_size
//
// One request enters per clock while the skid register is empty. From acceptance to the
// output register a request passes the input register, difference, range reduction, squaring
// and sum (5), the square-root pipeline with one root bit per stage (30), the divider with a
// numerator stage and one quotient bit per stage (17), brush scaling (3), corner stage (1),
// and the output register (1); a result that meets a stall waits in the skid register first.
// Reset clears all valid bits and loads the default brush size; payload registers are not reset.
// Stages up to the corner stage advance together while the skid register is empty. When the
// consumer stalls, the output register holds its result and the next one lands in the skid
// register, so the input keeps taking requests until both are full; nothing is dropped or repeated.
module stroke_segment_quad #(
  parameter int unsigned COORD_WIDTH = ssq_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = ssq_pkg::FRAC_BITS_DEF,
  localparam int unsigned IN_DW      = ((4 * COORD_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_DW     = ((8 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Fields from bit 0 up: start_x, start_y, end_x, end_y.
  input  logic [IN_DW-1:0]              s_axis_tdata,
  // Fields from bit 0 up: part_select.
  input  logic [1:0]                    s_axis_tuser,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0 up: corner1_x, corner1_y, corner2_x, corner2_y,
  // corner3_x, corner3_y, corner4_x, corner4_y.
  output logic [OUT_DW-1:0]             m_axis_tdata,
  // Fields from bit 0 up: degenerate.
  output logic [0:0]                    m_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_we_i,
  input  logic [ssq_pkg::BRUSH_W-1:0]   cfg_wdata_i
);

  localparam int unsigned W       = COORD_WIDTH;
  localparam int unsigned D_W     = W + 1;              // endpoint difference, signed
  localparam int unsigned NORM_W  = ssq_pkg::NORM_W;
  localparam int unsigned SH_W    = $clog2(D_W + 1);
  localparam int unsigned SCALE_W = ssq_pkg::SCALE_W;
  localparam int unsigned OFS_W   = 12 + FRAC_BITS;
  localparam int unsigned SUM_W   = ((W > OFS_W) ? W : OFS_W) + 2;
  // Sideband layouts. The common part carries the endpoints and the degenerate flag.
  localparam int unsigned COM_W   = 4 * W + 1;
  localparam int unsigned DSIDE_W = SCALE_W + 2 + COM_W;
  localparam int unsigned SSIDE_W = DSIDE_W + 2 * NORM_W;

  localparam logic signed [SUM_W-1:0] CMAX =
    {{(SUM_W - W + 1){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] CMIN = ~CMAX;

  // Global advance: every stage up to the corner stage moves while the skid register is free.
  logic en;
  logic skid_v_q, out_v_q;
  assign en            = !skid_v_q;
  assign s_axis_tready = en;

  // Brush size register.
  logic [ssq_pkg::BRUSH_W-1:0] brush_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brush_q <= ssq_pkg::BRUSH_RESET;
    end else if (cfg_we_i) begin
      brush_q <= cfg_wdata_i;
    end
  end

  // Stage A: input register and part scale lookup.
  logic                  va_q;
  logic signed [W-1:0]   sx_a_q, sy_a_q, ex_a_q, ey_a_q;
  logic [SCALE_W-1:0]    scale_a_q;

  // Stage B: differences, magnitudes and sign flags.
  logic                  vb_q;
  logic [COM_W-1:0]      com_b_q;
  logic [D_W-1:0]        adx_b_q, ady_b_q;
  logic [1:0]            neg_b_q;
  logic [SCALE_W-1:0]    scale_b_q;

  // Stage C: range reduction of the magnitudes to NORM_W bits.
  logic                  vc_q;
  logic [DSIDE_W-1:0]    dside_c_q;
  logic [NORM_W-1:0]     adx_c_q, ady_c_q;

  // Stage D: squares.
  logic                  vd_q;
  logic [DSIDE_W-1:0]    dside_d_q;
  logic [NORM_W-1:0]     adx_d_q, ady_d_q;
  logic [2*NORM_W-1:0]   sqx_d_q, sqy_d_q;

  // Stage E: squared length.
  logic                  ve_q;
  logic [SSIDE_W-1:0]    sside_e_q;
  logic [ssq_pkg::L2_W-1:0] l2_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else if (en) begin
      va_q <= s_axis_tvalid;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
    end
  end

  logic signed [D_W-1:0] dx, dy;
  assign dx = D_W'(ex_a_q) - D_W'(sx_a_q);
  assign dy = D_W'(ey_a_q) - D_W'(sy_a_q);

  // Shift that brings the larger magnitude below 2^NORM_W.
  logic [D_W-1:0]  mag_or;
  logic [SH_W-1:0] sh;
  assign mag_or = adx_b_q | ady_b_q;
  always_comb begin
    sh = '0;
    for (int i = 0; i < D_W; i++) begin
      if (i >= NORM_W && mag_or[i]) begin
        sh = SH_W'(i - NORM_W + 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_a_q    <= s_axis_tdata[0*W +: W];
      sy_a_q    <= s_axis_tdata[1*W +: W];
      ex_a_q    <= s_axis_tdata[2*W +: W];
      ey_a_q    <= s_axis_tdata[3*W +: W];
      scale_a_q <= ssq_pkg::part_scale(s_axis_tuser);

      com_b_q   <= {(dx == '0) && (dy == '0), ey_a_q, ex_a_q, sy_a_q, sx_a_q};
      adx_b_q   <= dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
      ady_b_q   <= dy[D_W-1] ? D_W'(-dy) : D_W'(dy);
      // The x offset takes the sign opposite to dy; the y offset takes the sign of dx.
      neg_b_q   <= {dx[D_W-1], (dy > 0)};
      scale_b_q <= scale_a_q;

      dside_c_q <= {scale_b_q, neg_b_q, com_b_q};
      adx_c_q   <= NORM_W'(adx_b_q >> sh);
      ady_c_q   <= NORM_W'(ady_b_q >> sh);

      dside_d_q <= dside_c_q;
      adx_d_q   <= adx_c_q;
      ady_d_q   <= ady_c_q;
      sqx_d_q   <= adx_c_q * adx_c_q;
      sqy_d_q   <= ady_c_q * ady_c_q;

      sside_e_q <= {dside_d_q, adx_d_q, ady_d_q};
      l2_e_q    <= ssq_pkg::L2_W'(sqx_d_q) + ssq_pkg::L2_W'(sqy_d_q);
    end
  end

  // Length in Q14.
  logic                          v_sq;
  logic [ssq_pkg::ROOT_W-1:0]    len_sq;
  logic [SSIDE_W-1:0]            sside_sq;

  ssq_sqrt #(
    .SIDE_W (SSIDE_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ve_q),
    .l2_i    (l2_e_q),
    .side_i  (sside_e_q),
    .valid_o (v_sq),
    .root_o  (len_sq),
    .side_o  (sside_sq)
  );

  // Lane 0 gives the x normal from |dy|, lane 1 the y normal from |dx|.
  logic [NORM_W-1:0]          div_mag [2];
  logic                       v_dv;
  logic [ssq_pkg::QUO_W-1:0]  norm_dv [2];
  logic [DSIDE_W-1:0]         dside_dv;

  assign div_mag[0] = sside_sq[0 +: NORM_W];
  assign div_mag[1] = sside_sq[NORM_W +: NORM_W];

  ssq_div #(
    .SIDE_W (DSIDE_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_sq),
    .len_i   (len_sq),
    .mag_i   (div_mag),
    .side_i  (sside_sq[2*NORM_W +: DSIDE_W]),
    .valid_o (v_dv),
    .quo_o   (norm_dv),
    .side_o  (dside_dv)
  );

  logic                     v_of;
  logic signed [OFS_W-1:0]  ofs_of [2];
  logic [COM_W-1:0]         com_of;

  ssq_offset #(
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (COM_W),
    .OFS_W     (OFS_W)
  ) u_offset (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_dv),
    .norm_i  (norm_dv),
    .neg_i   (dside_dv[COM_W +: 2]),
    .scale_i (dside_dv[COM_W + 2 +: SCALE_W]),
    .brush_i (brush_q),
    .side_i  (dside_dv[0 +: COM_W]),
    .valid_o (v_of),
    .ofs_o   (ofs_of),
    .side_o  (com_of)
  );

  // Corner stage: endpoints plus or minus the offset, saturated to the coordinate range.
  // A zero-length segment forces both offsets to zero.
  logic signed [W-1:0]     pt [4];
  logic signed [SUM_W-1:0] ox, oy;
  logic signed [SUM_W-1:0] raw [8];
  logic [8*W-1:0]          corners;
  logic                    degen;

  assign degen = com_of[4*W];
  for (genvar p = 0; p < 4; p++) begin : g_pt
    assign pt[p] = com_of[p*W +: W];
  end

  always_comb begin
    ox = degen ? '0 : SUM_W'(ofs_of[0]);
    oy = degen ? '0 : SUM_W'(ofs_of[1]);
    // Counter-clockwise: start - n, end - n, end + n, start + n.
    raw[0] = SUM_W'(pt[0]) - ox;
    raw[1] = SUM_W'(pt[1]) - oy;
    raw[2] = SUM_W'(pt[2]) - ox;
    raw[3] = SUM_W'(pt[3]) - oy;
    raw[4] = SUM_W'(pt[2]) + ox;
    raw[5] = SUM_W'(pt[3]) + oy;
    raw[6] = SUM_W'(pt[0]) + ox;
    raw[7] = SUM_W'(pt[1]) + oy;
    for (int c = 0; c < 8; c++) begin
      if (raw[c] > CMAX) begin
        corners[c*W +: W] = CMAX[W-1:0];
      end else if (raw[c] < CMIN) begin
        corners[c*W +: W] = CMIN[W-1:0];
      end else begin
        corners[c*W +: W] = raw[c][W-1:0];
      end
    end
  end

  logic               vk_q;
  logic [8*W:0]       res_k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vk_q <= 1'b0;
    end else if (en) begin
      vk_q <= v_of;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_k_q <= {degen, corners};
    end
  end

  // Output register with a skid register behind it.
  logic [8*W:0] out_q, skid_q;
  logic         pop;
  assign pop = out_v_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) begin
        skid_v_q <= 1'b0;
      end
    end else if (!out_v_q || pop) begin
      out_v_q <= vk_q;
    end else if (vk_q) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (!out_v_q || pop) begin
      out_q <= res_k_q;
    end else begin
      skid_q <= res_k_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OUT_DW'(out_q[8*W-1:0]);
  assign m_axis_tuser  = out_q[8*W];

  // The skid register is only ever occupied behind a held result.
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register holds a result while the output register is empty");

  // The skid register fills only when the output was stalled in the previous cycle.
  a_skid_fill_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !m_axis_tready))
    else $error("skid register filled without an output stall");

  // A zero-length segment leaves the start corners and the end corners on the endpoints.
  a_degenerate_zero_offset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (out_q[0 +: W] == out_q[6*W +: W]) && (out_q[W +: W] == out_q[7*W +: W]) &&
      (out_q[2*W +: W] == out_q[4*W +: W]) && (out_q[3*W +: W] == out_q[5*W +: W]))
    else $error("degenerate result with a nonzero offset");

endmodule

>>> dv/tb_stroke_segment_quad.sv
// Self-checking testbench for the stroke segment quad expander: directed table, brush sweep,
// long output stall, random segments with random handshake gaps; checked by an in-bench predictor.
// Depends on ssq_pkg and the stroke_segment_quad RTL.
module tb_stroke_segment_quad;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW      = 16;
  localparam int unsigned LATENCY = 60;
  localparam int unsigned N_RAND  = 1330;

  typedef struct packed {
    logic [CW-1:0] c4y, c4x, c3y, c3x, c2y, c2x, c1y, c1x;
    logic          degen;
  } quad_t;

  typedef struct {
    logic signed [CW-1:0] sx, sy, ex, ey;
    ssq_pkg::part_e       part;
    logic                 known;    // corners are the endpoints themselves
    logic                 degen;    // expected flag for known rows
  } seg_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic [63:0]         s_axis_tdata = '0;
  logic [1:0]          s_axis_tuser = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [127:0]        m_axis_tdata;
  logic [0:0]          m_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [ssq_pkg::BRUSH_W-1:0] cfg_wdata_i = '0;

  // Brush size as the block currently holds it.
  logic [ssq_pkg::BRUSH_W-1:0] brush_q = ssq_pkg::BRUSH_RESET;
  quad_t               quad_q[$];
  int unsigned         n_fail = 0;
  int unsigned         n_quads = 0;
  int unsigned         n_degen = 0;
  int unsigned         n_taken = 0;
  int unsigned         n_seen = 0;
  int unsigned         rx_wait = 0;
  logic                hold_off = 1'b0;
  logic                stall_mode = 1'b1;

  always #1 clk_i = ~clk_i;

  stroke_segment_quad i_dut (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tuser, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tuser, .m_axis_tvalid, .m_axis_tready,
    .cfg_we_i, .cfg_wdata_i
  );

  function automatic logic [CW-1:0] clamp_coord(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[CW-1:0];
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Offset magnitude from a Q2.14 normal component, rounded half up.
  function automatic longint offset_mag(longint unsigned n, longint unsigned sc);
    longint unsigned p;
    p = n * sc * brush_q * 16;
    return longint'((p + (64'd1 << 22)) >> 23);
  endfunction

  function automatic quad_t predict_quad(seg_t s);
    quad_t q;
    longint sx, sy, ex, ey, dx, dy, ox, oy;
    longint unsigned adx, ady, lenq, nx, ny, sc;
    sx = s.sx; sy = s.sy; ex = s.ex; ey = s.ey;
    dx = ex - sx;
    dy = ey - sy;
    ox = 0; oy = 0;
    case (s.part)
      ssq_pkg::PART_TIP: sc = 84;
      ssq_pkg::PART_MID: sc = 172;
      default:           sc = 256;
    endcase
    q.degen = (dx == 0 && dy == 0);
    if (!q.degen) begin
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      while (adx >= 32768 || ady >= 32768) begin
        adx >>= 1;
        ady >>= 1;
      end
      lenq = root64((adx * adx + ady * ady) << 28);
      if (lenq == 0) lenq = 1;
      nx = ((ady << 28) + (lenq >> 1)) / lenq;
      ny = ((adx << 28) + (lenq >> 1)) / lenq;
      ox = offset_mag(nx, sc);
      oy = offset_mag(ny, sc);
      if (dy > 0) ox = -ox;
      if (dx < 0) oy = -oy;
    end
    q.c1x = clamp_coord(sx - ox); q.c1y = clamp_coord(sy - oy);
    q.c2x = clamp_coord(ex - ox); q.c2y = clamp_coord(ey - oy);
    q.c3x = clamp_coord(ex + ox); q.c3y = clamp_coord(ey + oy);
    q.c4x = clamp_coord(sx + ox); q.c4y = clamp_coord(sy + oy);
    return q;
  endfunction

  // Drives one request on the falling edge and waits for its acceptance. The request stays
  // on the bus until the next request, a gap or a drain takes it off.
  task automatic send_segment(seg_t s, int unsigned gap);
    quad_t q;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    q = predict_quad(s);
    if (s.known) begin
      // Rows whose corners are the endpoints themselves.
      q.degen = s.degen;
      q.c1x = s.sx; q.c1y = s.sy; q.c4x = s.sx; q.c4y = s.sy;
      q.c2x = s.ex; q.c2y = s.ey; q.c3x = s.ex; q.c3y = s.ey;
    end
    s_axis_tdata  <= {s.ey, s.ex, s.sy, s.sx};
    s_axis_tuser  <= s.part;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    quad_q.push_back(q);
    @(negedge clk_i);
  endtask

  // Takes the request off the bus and waits until every expected result is back.
  task automatic drain_input();
    s_axis_tvalid <= 1'b0;
    wait (quad_q.size() == 0);
    @(negedge clk_i);
  endtask

  task automatic write_brush(logic [ssq_pkg::BRUSH_W-1:0] v);
    drain_input();
    repeat (LATENCY) @(negedge clk_i);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    brush_q = v;
  endtask

  function automatic seg_t rand_segment();
    seg_t s;
    int unsigned span;
    s.known = 1'b0;
    s.degen = 1'b0;
    s.part  = ssq_pkg::part_e'($urandom_range(3, 0));
    s.sx = CW'($urandom); s.sy = CW'($urandom);
    case ($urandom_range(5, 0))
      0: begin s.ex = CW'($urandom); s.ey = CW'($urandom); end
      1: begin s.ex = s.sx; s.ey = s.sy; end
      2: begin s.ex = s.sx; s.ey = CW'($urandom); end
      default: begin
        // Short strokes, as a pen produces them.
        span = 1 << $urandom_range(12, 1);
        s.ex = CW'(s.sx + $signed($urandom_range(2 * span, 0)) - span);
        s.ey = CW'(s.sy + $signed($urandom_range(2 * span, 0)) - span);
      end
    endcase
    return s;
  endfunction

  // Receiver: holds off while hold_off is set, is always ready while stall_mode is clear,
  // and otherwise draws a random wait before each result.
  always @(negedge clk_i) begin
    if (n_taken != n_seen) begin
      n_seen  = n_taken;
      rx_wait = $urandom_range(15, 0);
    end
    if (hold_off) begin
      m_axis_tready <= 1'b0;
    end else if (!stall_mode) begin
      m_axis_tready <= 1'b1;
    end else if (rx_wait != 0) begin
      m_axis_tready <= 1'b0;
      rx_wait--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    quad_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      n_taken++;
      got = {m_axis_tdata, m_axis_tuser};
      if (quad_q.size() == 0) begin
        $display("%0t: unexpected quad %h", $time, got);
        n_fail++;
      end else begin
        want = quad_q.pop_front();
        n_quads++;
        if (got.degen) n_degen++;
        if (got !== want) begin
          $display("%0t: quad mismatch expected %h actual %h", $time, want, got);
          n_fail++;
        end
      end
    end
  end

  seg_t table_q[$];

  initial begin
    seg_t s;
    int unsigned i;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // Directed rows: degenerate, axis-aligned, diagonals, extremes, every part select.
    table_q.push_back('{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, ssq_pkg::PART_TIP, 1, 1});
    table_q.push_back('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, ssq_pkg::PART_BASE, 1, 1});
    table_q.push_back('{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, ssq_pkg::PART_UNUSED,
                        1, 1});
    table_q.push_back('{16'sh0000, 16'sh0000, 16'sh0100, 16'sh0000, ssq_pkg::PART_TIP, 0, 0});
    table_q.push_back('{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0100, ssq_pkg::PART_MID, 0, 0});
    table_q.push_back('{16'sh0000, 16'sh0000, -16'sh0100, 16'sh0000, ssq_pkg::PART_BASE,
                        0, 0});
    table_q.push_back('{16'sh0000, 16'sh0000, 16'sh0000, -16'sh0100, ssq_pkg::PART_UNUSED,
                        0, 0});
    table_q.push_back('{16'sh0010, 16'sh0010, 16'sh0020, 16'sh0020, ssq_pkg::PART_MID, 0, 0});
    table_q.push_back('{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, ssq_pkg::PART_BASE, 0, 0});
    table_q.push_back('{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, ssq_pkg::PART_BASE, 0, 0});
    table_q.push_back('{16'sh8000, 16'sh0000, 16'sh7fff, 16'sh0000, ssq_pkg::PART_TIP, 0, 0});
    table_q.push_back('{16'sh7ff8, 16'sh0000, 16'sh7fff, 16'sh0001, ssq_pkg::PART_BASE, 0, 0});
    table_q.push_back('{16'sh8004, 16'sh8002, 16'sh8001, 16'sh8000, ssq_pkg::PART_BASE, 0, 0});
    table_q.push_back('{16'sh0000, 16'sh0000, 16'sh0001, 16'sh0000, ssq_pkg::PART_MID, 0, 0});
    table_q.push_back('{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0001, ssq_pkg::PART_TIP, 0, 0});
    table_q.push_back('{16'sh1234, -16'sh0567, -16'sh2345, 16'sh3456, ssq_pkg::PART_MID,
                        0, 0});
    foreach (table_q[k]) send_segment(table_q[k], 0);

    // Brush sweep including both extremes.
    write_brush(8'd0);
    for (i = 0; i < 8; i++) send_segment(table_q[3 + i], 0);
    write_brush(8'd255);
    for (i = 0; i < 13; i++) send_segment(table_q[3 + i], 0);

    // Consumer holds off for a long stretch while requests keep coming.
    hold_off = 1'b1;
    fork
      begin
        repeat (200) @(negedge clk_i);
        hold_off = 1'b0;
      end
      for (i = 0; i < 80; i++) send_segment(rand_segment(), 0);
    join

    for (i = 0; i < N_RAND; i++) begin
      if (i % 300 == 299) write_brush(8'($urandom_range(255, 0)));
      if (i % 400 == 200) stall_mode = ~stall_mode;
      // Sender pause until the pipeline drains.
      if (i == 700) drain_input();
      s = rand_segment();
      send_segment(s, (i % 250 < 60) ? 0 : $urandom_range(15, 0));
    end

    stall_mode = 1'b0;
    drain_input();
    repeat (LATENCY) @(negedge clk_i);
    $display("Checked %0d quads (%0d degenerate) over several brush sizes,", n_quads, n_degen);
    $display("all part selects, saturating extremes and long output back-pressure.");
    if (n_fail == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout with %0d quads outstanding", quad_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
